[rtl/sapq_pkg.sv]
// Shared types and codes for the slot-array queue with peek.
// Depends on nothing; the top level, sapq_ptr, the checker and the testbench import it.
package sapq_pkg;

    // Operation carried with each input transfer.
    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_FRONT = 2'd2,
        CMD_REAR  = 2'd3
    } cmd_t;

    // Completion code carried with each result transfer.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } state_t;

    // Occupancy flags from the pointer unit.
    typedef struct packed {
        logic empty;
        logic full;
    } ptr_flags_t;

    // Width of the data field on the result channel.
    localparam int unsigned OUT_WIDTH = 32;

endpackage

[rtl/slot_array_queue_with_peek_core.sv]
// Top level of the slot-array queue with front and rear peek.
// Depends on sapq_pkg, sapq_ptr and sapq_ram.
//
//  Channel   Direction  Handshake          Payload
//  s_axis    in         s_tvalid/s_tready  s_tdata: value, s_tuser: cmd
//  m_axis    out        m_tvalid/m_tready  m_tdata: data,  m_tuser: status
//
// In S_IDLE a command issues the data RAM access and updates the pointers;
// in S_RESP the registered RAM read is taken into the output register.
// A new command is taken only back in S_IDLE, once the previous result has
// moved into the output register.
// Reset clears the pointers, the sequencer and the output valid; the data RAM
// needs no clearing, since only slots between head and tail are ever read.
// A stalled result holds in the output register; one further command may be
// taken meanwhile and then waits with its RAM data until the register frees.
module slot_array_queue_with_peek_core
    import sapq_pkg::*;
#(
    parameter int unsigned CAPACITY   = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input stream.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]         s_tuser,   // [1:0] cmd
    // Result stream.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic signed [31:0] m_tdata,   // [31:0] data
    output logic [1:0]         m_tuser    // [1:0] status
);

    localparam int unsigned AW = $clog2(CAPACITY);

    state_t                  state_reg;
    state_t                  state_next;
    status_t                 pend_status_reg;
    status_t                 pend_status_next;
    logic                    pend_data_reg;
    logic                    pend_data_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    status_t                 out_status_next;
    logic [OUT_WIDTH-1:0]    out_data_reg;
    logic [OUT_WIDTH-1:0]    out_data_next;

    cmd_t                    cmd;
    logic                    accept;
    logic                    out_free;
    ptr_flags_t              flags;
    logic [AW-1:0]           head_addr;
    logic [AW-1:0]           tail_addr;
    logic [AW-1:0]           rear_addr;
    logic                    ram_we;
    logic                    ram_re;
    logic [AW-1:0]           ram_addr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic [DATA_WIDTH-1:0]   ram_rdata;
    logic [63:0]             rd_ext;

    assign cmd      = cmd_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Pointer unit.
    sapq_ptr #(
        .CAPACITY (CAPACITY)
    ) u_ptr (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (accept),
        .cmd       (cmd),
        .flags     (flags),
        .head_addr (head_addr),
        .tail_addr (tail_addr),
        .rear_addr (rear_addr)
    );

    // Data RAM: write on enqueue, read on dequeue and both peeks.
    assign ram_we    = accept && (cmd == CMD_ENQ) && !flags.full;
    assign ram_re    = accept && (cmd != CMD_ENQ) && !flags.empty;
    assign ram_addr  = (cmd == CMD_ENQ)  ? tail_addr :
                       (cmd == CMD_REAR) ? rear_addr : head_addr;
    assign ram_wdata = DATA_WIDTH'(64'($unsigned(s_tdata)));

    sapq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_ext = 64'(ram_rdata);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath registers.
    always_comb
    begin
        s_tready         = 1'b0;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    pend_data_next = 1'b0;
                    if (cmd == CMD_ENQ)
                    begin
                        pend_status_next = flags.full ? STATUS_FULL : STATUS_OK;
                    end
                    else if (flags.empty)
                    begin
                        pend_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        pend_status_next = STATUS_OK;
                        pend_data_next   = 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_data_next   = pend_data_reg ? rd_ext[OUT_WIDTH-1:0] : '0;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = $signed(out_data_reg);
    assign m_tuser  = out_status_reg;

endmodule

[rtl/sapq_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing; read data holds while no read is issued.
module sapq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access a cycle: write or registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sapq_ptr.sv]
// Head and tail pointers of the slot array, with empty and full flags.
// Depends on sapq_pkg. Occupied slots always form the range [head, tail),
// since slots fill only at the tail and dequeue clears only the lowest one.
module sapq_ptr
    import sapq_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        upd,
    input  cmd_t                        cmd,
    output ptr_flags_t                  flags,
    output logic [$clog2(CAPACITY)-1:0] head_addr,
    output logic [$clog2(CAPACITY)-1:0] tail_addr,
    output logic [$clog2(CAPACITY)-1:0] rear_addr
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] PTR_FULL = PW'(CAPACITY);

    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [PW-1:0] tail_reg;
    logic [PW-1:0] tail_next;
    logic [PW-1:0] rear_ptr;

    // Flags come straight from the registered pointers.
    assign flags.empty = (head_reg == tail_reg);
    assign flags.full  = (tail_reg == PTR_FULL);

    assign rear_ptr  = tail_reg - PW'(1);
    assign head_addr = head_reg[AW-1:0];
    assign tail_addr = tail_reg[AW-1:0];
    assign rear_addr = rear_ptr[AW-1:0];

    // Enqueue advances the tail, dequeue advances the head.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (upd)
        begin
            case (cmd)
                CMD_ENQ:
                begin
                    if (!flags.full)
                    begin
                        tail_next = tail_reg + PW'(1);
                    end
                end
                CMD_DEQ:
                begin
                    if (!flags.empty)
                    begin
                        head_next = head_reg + PW'(1);
                    end
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule

[rtl/sapq_checker.sv]
// Port-level checks for the slot-array queue, bound to the top level.
// Depends on sapq_pkg and the port list of slot_array_queue_with_peek_core.
module sapq_checker
    import sapq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic signed [31:0] s_tdata,
    input logic [1:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic signed [31:0] m_tdata,
    input logic [1:0]         m_tuser
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Empty and full results carry a zero data word.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_EMPTY || m_tuser == STATUS_FULL) |-> m_tdata == 0)
        else $error("nonzero data on empty or full result");

    // A command transfer is never followed by another in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken in consecutive cycles");

    // Every command transfer must be followed by a result on offer.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result after command");

endmodule

bind slot_array_queue_with_peek_core sapq_checker u_sapq_checker (.*);

[tb/sv/tb_slot_array_queue_with_peek_core.sv]
// Self-checking testbench for slot_array_queue_with_peek_core.
// Depends on sapq_pkg and the block's RTL. It predicts every result from its own
// queue model and runs directed, random, back-pressure and fill-to-full phases.
`timescale 1ns / 1ps

module tb_slot_array_queue_with_peek_core;
    import sapq_pkg::*;

    localparam int unsigned CAPACITY   = 1024;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 300;

    // Idling modes for the sender and the receiver.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        cmd_t        op;
        logic [31:0] word;
    } queue_cmd_t;

    typedef struct {
        status_t     st;
        logic [31:0] dat;
    } queue_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic signed [31:0] s_tdata;   // [31:0] value
    logic [1:0]         s_tuser;   // [1:0] cmd
    logic               m_tvalid;
    logic               m_tready;
    logic signed [31:0] m_tdata;   // [31:0] data
    logic [1:0]         m_tuser;   // [1:0] status

    // Commands waiting to be driven and results the queue model expects.
    queue_cmd_t    cmd_backlog[$];
    queue_result_t awaited_results[$];

    // Shadow copy of the queue state.
    logic [31:0]   shadow_word[CAPACITY];
    bit            shadow_busy[CAPACITY];
    int unsigned   shadow_tail;

    idle_mode_t    idle_mode = IDLE_NONE;
    bit            hold_req = 1'b0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;
    bit            in_taken = 1'b0;
    int unsigned   err_count = 0;
    int unsigned   cmds_taken = 0;
    int unsigned   results_checked = 0;
    int unsigned   full_seen = 0;
    int unsigned   empty_seen = 0;
    int unsigned   quiet_cycles = 0;

    // Stimulus-side bookkeeping: slots used so far.
    int unsigned   issued_tail = 0;

    slot_array_queue_with_peek_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one accepted command to the shadow state and queue its result.
    function automatic void queue_model_step(input cmd_t op, input logic [31:0] word);
        queue_result_t r;
        int            slot;
        int            k;
        r.st = STATUS_OK;
        r.dat = '0;
        slot = -1;
        if (op == CMD_ENQ)
        begin
            if (shadow_tail >= CAPACITY)
                r.st = STATUS_FULL;
            else
            begin
                shadow_word[shadow_tail] = word;
                shadow_busy[shadow_tail] = 1'b1;
                shadow_tail++;
            end
        end
        else
        begin
            if (op == CMD_REAR)
            begin
                for (k = int'(shadow_tail) - 1; k >= 0 && slot < 0; k--)
                    if (shadow_busy[k])
                        slot = k;
            end
            else
            begin
                for (k = 0; k < int'(shadow_tail) && slot < 0; k++)
                    if (shadow_busy[k])
                        slot = k;
            end
            if (slot < 0)
                r.st = STATUS_EMPTY;
            else
            begin
                r.dat = shadow_word[slot];
                if (op == CMD_DEQ)
                    shadow_busy[slot] = 1'b0;
            end
        end
        awaited_results.push_back(r);
    endfunction

    // Queue one command for the driver and track where the tail will go.
    task automatic push_cmd(input cmd_t op, input logic [31:0] word);
        queue_cmd_t c;
        c.op = op;
        c.word = word;
        cmd_backlog.push_back(c);
        if (op == CMD_ENQ && issued_tail < CAPACITY)
            issued_tail++;
    endtask

    // Random data word, with the extremes mixed in now and then.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: pick_word = 32'h8000_0000;
            1: pick_word = 32'h7FFF_FFFF;
            2: pick_word = 32'hFFFF_FFFF;
            3: pick_word = 32'h0000_0000;
            default: pick_word = $urandom;
        endcase
    endfunction

    // Random operation: half enqueues, the rest split among the reads.
    function automatic cmd_t pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            pick_op = CMD_ENQ;
        else if (roll < 75)
            pick_op = CMD_DEQ;
        else if (roll < 87)
            pick_op = CMD_FRONT;
        else
            pick_op = CMD_REAR;
    endfunction

    // Let every queued command go in and every result come back.
    task automatic wait_all_done();
        while (cmd_backlog.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_burst(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            push_cmd(pick_op(), pick_word());
    endtask

    // Driver: offers the next command at the falling edge once the last one is taken.
    always @(negedge clk)
    begin
        queue_cmd_t c;
        bit         idle_now;
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                case (idle_mode)
                    IDLE_SENDER: idle_now = ($urandom_range(0, 99) < 61);
                    IDLE_BOTH:   idle_now = ($urandom_range(0, 99) < 14);
                    default:     idle_now = 1'b0;
                endcase
                if (cmd_backlog.size() != 0 && !idle_now)
                begin
                    c = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.op;
                    s_tdata <= c.word;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        bit          stall_now;
        if (rst_n)
        begin
            case (idle_mode)
                IDLE_RECEIVER: stall_now = ($urandom_range(0, 99) < 61);
                IDLE_BOTH:     stall_now = ($urandom_range(0, 99) < 14);
                default:       stall_now = 1'b0;
            endcase
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !stall_now;
        end
    end

    // Monitor: checks results and feeds accepted commands to the queue model.
    always @(posedge clk)
    begin
        queue_result_t want;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if ((m_tvalid && m_tready) === 1'b1)
            begin
                moved = 1'b1;
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no result expected: status %0d data %h",
                           m_tuser, m_tdata);
                    err_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (want.st == STATUS_FULL)
                        full_seen++;
                    if (want.st == STATUS_EMPTY)
                        empty_seen++;
                    if (m_tuser !== want.st)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.st, m_tuser);
                        err_count++;
                    end
                    if (m_tdata !== want.dat)
                    begin
                        $error("data mismatch: expected %h, got %h", want.dat, m_tdata);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) === 1'b1)
            begin
                moved = 1'b1;
                cmds_taken++;
                queue_model_step(cmd_t'(s_tuser), s_tdata);
                in_taken <= 1'b1;
            end
            else
                in_taken <= 1'b0;

            // Watchdog on cycles without any transfer.
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int unsigned n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_ENQ;
        m_tready = 1'b0;
        shadow_tail = 0;
        for (n = 0; n < CAPACITY; n++)
            shadow_busy[n] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reads on an empty queue, extreme words, draining to empty.
        push_cmd(CMD_DEQ, 32'hFFFF_FFFF);
        push_cmd(CMD_FRONT, 32'h0000_0000);
        push_cmd(CMD_REAR, 32'h1234_5678);
        push_cmd(CMD_ENQ, 32'h7FFF_FFFF);
        push_cmd(CMD_ENQ, 32'h8000_0000);
        push_cmd(CMD_ENQ, 32'h0000_0000);
        push_cmd(CMD_ENQ, 32'hFFFF_FFFF);
        push_cmd(CMD_ENQ, 32'h0000_0001);
        push_cmd(CMD_FRONT, 32'hFFFF_FFFF);
        push_cmd(CMD_REAR, 32'h0000_0000);
        push_cmd(CMD_DEQ, 32'hAAAA_AAAA);
        push_cmd(CMD_FRONT, 32'h5555_5555);
        push_cmd(CMD_REAR, 32'hAAAA_AAAA);
        push_cmd(CMD_DEQ, 32'h0);
        push_cmd(CMD_DEQ, 32'h0);
        push_cmd(CMD_DEQ, 32'h0);
        push_cmd(CMD_DEQ, 32'h0);
        push_cmd(CMD_DEQ, 32'h0);
        push_cmd(CMD_REAR, 32'h0);
        push_cmd(CMD_ENQ, 32'hDEAD_BEEF);
        push_cmd(CMD_FRONT, 32'h0);
        push_cmd(CMD_REAR, 32'h0);
        push_cmd(CMD_DEQ, 32'h0);
        push_cmd(CMD_FRONT, 32'h0);
        wait_all_done();

        // Random traffic under each idling pattern.
        idle_mode = IDLE_NONE;
        random_burst(40);
        wait_all_done();
        idle_mode = IDLE_SENDER;
        random_burst(40);
        wait_all_done();
        idle_mode = IDLE_RECEIVER;
        random_burst(40);
        wait_all_done();
        idle_mode = IDLE_BOTH;
        random_burst(40);
        wait_all_done();

        // Long receiver hold-off while the sender keeps offering commands.
        idle_mode = IDLE_NONE;
        hold_req = 1'b1;
        random_burst(40);
        wait_all_done();

        // Fill to capacity, then enqueue into a full queue mixed with reads.
        idle_mode = IDLE_BOTH;
        while (issued_tail < CAPACITY)
        begin
            if ($urandom_range(0, 19) == 0)
                push_cmd(($urandom_range(0, 1) != 0) ? CMD_FRONT : CMD_REAR, pick_word());
            else
                push_cmd(CMD_ENQ, pick_word());
        end
        for (n = 0; n < 20; n++)
            push_cmd(($urandom_range(0, 1) != 0) ? CMD_ENQ : pick_op(), pick_word());
        wait_all_done();

        // A few more commands; the queue stays full, so enqueues keep failing.
        idle_mode = IDLE_NONE;
        for (n = 0; n < 12; n++)
            push_cmd(pick_op(), pick_word());
        wait_all_done();

        // Allow any stray result to surface.
        repeat (20) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            err_count++;
        end
        $display("Checked %0d results for %0d commands (%0d full, %0d empty).",
                 results_checked, cmds_taken, full_seen, empty_seen);
        $display("Covered empty reads, fill to capacity, enqueue when full, stalls and a hold-off.");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
